// File: rtl/pidc_pkg.sv
// Shared types, register indexes and reset values for the PID controller.
package pidc_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_TOTAL_GAIN        = 3'd0;
    localparam logic [2:0] REG_PROPORTIONAL_GAIN = 3'd1;
    localparam logic [2:0] REG_INTEGRAL_GAIN     = 3'd2;
    localparam logic [2:0] REG_DERIVATIVE_GAIN   = 3'd3;
    localparam logic [2:0] REG_TIME_STEP         = 3'd4;
    localparam logic [2:0] REG_OUTPUT_GAIN       = 3'd5;
    localparam logic [2:0] REG_DRIVE_MAX         = 3'd6;
    localparam logic [2:0] REG_DRIVE_MIN         = 3'd7;

    localparam logic [31:0] RST_TOTAL_GAIN  = 32'h0001_0000;
    localparam logic [30:0] RST_TIME_STEP   = 31'h0001_0000;
    localparam logic [31:0] RST_OUTPUT_GAIN = 32'h0001_0000;
    localparam logic [31:0] RST_DRIVE_MAX   = 32'h000A_0000;
    localparam logic [31:0] RST_DRIVE_MIN   = 32'hFFF6_0000;

    typedef struct packed {
        logic [31:0] total_gain;
        logic [31:0] proportional_gain;
        logic [31:0] integral_gain;
        logic [31:0] derivative_gain;
        logic [30:0] time_step;
        logic [31:0] output_gain;
        logic [31:0] drive_max;
        logic [31:0] drive_min;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic long_op;
    } mul_ctl_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] drive;
        logic        clamped;
    } res_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            r = v[31:0];
        end
        else
        begin
            r = {v[33], {31{~v[33]}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/pidc_regs.sv
// APB register file holding the controller gains, time step and drive limits.
module pidc_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pidc_pkg::DATA_W-1:0]          pwdata,
    output logic [pidc_pkg::DATA_W-1:0]          prdata,
    output pidc_pkg::cfg_t                       cfg
);

    pidc_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[4:2];
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_gain        <= pidc_pkg::RST_TOTAL_GAIN;
            cfg_reg.proportional_gain <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.derivative_gain   <= '0;
            cfg_reg.time_step         <= pidc_pkg::RST_TIME_STEP;
            cfg_reg.output_gain       <= pidc_pkg::RST_OUTPUT_GAIN;
            cfg_reg.drive_max         <= pidc_pkg::RST_DRIVE_MAX;
            cfg_reg.drive_min         <= pidc_pkg::RST_DRIVE_MIN;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pidc_pkg::REG_TOTAL_GAIN:        cfg_reg.total_gain        <= pwdata;
                pidc_pkg::REG_PROPORTIONAL_GAIN: cfg_reg.proportional_gain <= pwdata;
                pidc_pkg::REG_INTEGRAL_GAIN:     cfg_reg.integral_gain     <= pwdata;
                pidc_pkg::REG_DERIVATIVE_GAIN:   cfg_reg.derivative_gain   <= pwdata;
                pidc_pkg::REG_TIME_STEP:         cfg_reg.time_step         <= pwdata[30:0];
                pidc_pkg::REG_OUTPUT_GAIN:       cfg_reg.output_gain       <= pwdata;
                pidc_pkg::REG_DRIVE_MAX:         cfg_reg.drive_max         <= pwdata;
                pidc_pkg::REG_DRIVE_MIN:         cfg_reg.drive_min         <= pwdata;
                default:                         cfg_reg.drive_min         <= cfg_reg.drive_min;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pidc_pkg::REG_TOTAL_GAIN:        prdata = cfg_reg.total_gain;
            pidc_pkg::REG_PROPORTIONAL_GAIN: prdata = cfg_reg.proportional_gain;
            pidc_pkg::REG_INTEGRAL_GAIN:     prdata = cfg_reg.integral_gain;
            pidc_pkg::REG_DERIVATIVE_GAIN:   prdata = cfg_reg.derivative_gain;
            pidc_pkg::REG_TIME_STEP:         prdata = {1'b0, cfg_reg.time_step};
            pidc_pkg::REG_OUTPUT_GAIN:       prdata = cfg_reg.output_gain;
            pidc_pkg::REG_DRIVE_MAX:         prdata = cfg_reg.drive_max;
            pidc_pkg::REG_DRIVE_MIN:         prdata = cfg_reg.drive_min;
            default:                         prdata = '0;
        endcase
    end

endmodule

// File: rtl/pidc_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module pidc_mul #(
    parameter int FB = 16,
    parameter int IB = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pidc_pkg::mul_ctl_t      ctl,
    input  logic [31:0]             a,
    input  logic [IB-1:0]           b,
    output logic                    done,
    output logic [IB+32:0]          prod_sh,
    output logic [31:0]             prod_sat
);

    localparam int PW = IB + 33;
    localparam int CW = $clog2(IB);

    logic [31:0]          a_reg;
    logic [32:0]          hi_reg;
    logic [IB-1:0]        lo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 long_reg;
    logic                 done_reg;

    logic                 last;
    logic signed [33:0]   addend;
    logic signed [33:0]   acc_ext;
    logic signed [33:0]   t;
    logic signed [PW-1:0] full;
    logic signed [PW-1:0] shifted;
    logic [PW-32:0]       upper;

    assign last    = long_reg ? (cnt_reg == CW'(IB - 1)) : (cnt_reg == CW'(31));
    assign addend  = lo_reg[0] ? $signed({a_reg[31], a_reg[31], a_reg}) : 34'sd0;
    assign acc_ext = $signed({hi_reg[32], hi_reg});
    assign t       = last ? (acc_ext - addend) : (acc_ext + addend);

    assign full    = $signed({hi_reg, lo_reg});
    assign shifted = long_reg ? (full >>> FB) : (full >>> (FB + IB - 32));
    assign upper   = shifted[PW-1:31];

    always_comb
    begin
        if ((&upper) || !(|upper))
        begin
            prod_sat = shifted[31:0];
        end
        else
        begin
            prod_sat = {upper[PW-32], {31{~upper[PW-32]}}};
        end
    end

    assign prod_sh = shifted;
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            long_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            long_reg <= ctl.long_op;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= t[33:1];
            lo_reg <= {t[0], lo_reg[IB-1:1]};
        end
    end

endmodule

// File: rtl/pidc_seq.sv
// Sequencer and datapath: error, integrator, terms, gains and output clamp.
module pidc_seq #(
    parameter int FB = 16,
    parameter int IB = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             measured,
    input  logic [31:0]             setpoint,
    input  pidc_pkg::cfg_t          cfg,
    input  logic                    out_free,
    output pidc_pkg::res_t          res,
    output pidc_pkg::mul_ctl_t      mul_ctl,
    output logic [31:0]             mul_a,
    output logic [IB-1:0]           mul_b,
    input  logic                    mul_done,
    input  logic [IB+32:0]          mul_sh,
    input  logic [31:0]             mul_sat
);

    localparam int SW = IB + 34;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_GO_TS = 4'd1;
    localparam logic [3:0] ST_W_TS  = 4'd2;
    localparam logic [3:0] ST_GO_P  = 4'd3;
    localparam logic [3:0] ST_W_P   = 4'd4;
    localparam logic [3:0] ST_GO_I  = 4'd5;
    localparam logic [3:0] ST_W_I   = 4'd6;
    localparam logic [3:0] ST_GO_D  = 4'd7;
    localparam logic [3:0] ST_W_D   = 4'd8;
    localparam logic [3:0] ST_SUM   = 4'd9;
    localparam logic [3:0] ST_GO_U  = 4'd10;
    localparam logic [3:0] ST_W_U   = 4'd11;
    localparam logic [3:0] ST_GO_V  = 4'd12;
    localparam logic [3:0] ST_W_V   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [31:0]        err_reg;
    logic [31:0]        prev_reg;
    logic [IB-1:0]      integ_reg;
    logic [31:0]        opnd_reg;
    logic [33:0]        term_reg;
    logic [31:0]        drive_reg;
    logic               clamped_reg;

    logic [31:0]        err_in;
    logic [31:0]        diff;
    logic signed [SW-1:0] isum;
    logic [SW-IB:0]     iupper;
    logic [IB-1:0]      integ_new;
    logic [33:0]        term_add;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               cl;

    assign err_in = pidc_pkg::sat32(34'($signed(setpoint)) - 34'($signed(measured)));
    assign diff   = pidc_pkg::sat32(34'($signed(err_reg)) - 34'($signed(prev_reg)));

    assign isum   = SW'($signed(integ_reg)) + SW'($signed(mul_sh));
    assign iupper = isum[SW-1:IB-1];

    always_comb
    begin
        if ((&iupper) || !(|iupper))
        begin
            integ_new = isum[IB-1:0];
        end
        else
        begin
            integ_new = {isum[SW-1], {(IB-1){~isum[SW-1]}}};
        end
    end

    assign term_add = term_reg + 34'($signed(mul_sat));

    always_comb
    begin
        v0 = $signed(mul_sat);
        cl = 1'b0;
        v1 = v0;
        if (v0 > $signed(cfg.drive_max))
        begin
            v1 = $signed(cfg.drive_max);
            cl = 1'b1;
        end
        v2 = v1;
        if (v1 < $signed(cfg.drive_min))
        begin
            v2 = $signed(cfg.drive_min);
            cl = 1'b1;
        end
    end

    always_comb
    begin
        mul_ctl.start   = 1'b0;
        mul_ctl.long_op = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (state_reg)
            ST_GO_TS:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = err_reg;
                mul_b         = IB'({1'b0, cfg.time_step});
            end
            ST_GO_P:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = cfg.proportional_gain;
                mul_b         = IB'($signed(err_reg));
            end
            ST_GO_I:
            begin
                mul_ctl.start   = 1'b1;
                mul_ctl.long_op = 1'b1;
                mul_a           = cfg.integral_gain;
                mul_b           = integ_reg;
            end
            ST_GO_D:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = cfg.derivative_gain;
                mul_b         = IB'($signed(opnd_reg));
            end
            ST_GO_U:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = cfg.total_gain;
                mul_b         = IB'($signed(opnd_reg));
            end
            ST_GO_V:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = cfg.output_gain;
                mul_b         = IB'($signed(opnd_reg));
            end
            default:
            begin
                mul_ctl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_GO_TS;
            ST_GO_TS: state_next = ST_W_TS;
            ST_W_TS:  if (mul_done) state_next = ST_GO_P;
            ST_GO_P:  state_next = ST_W_P;
            ST_W_P:   if (mul_done) state_next = ST_GO_I;
            ST_GO_I:  state_next = ST_W_I;
            ST_W_I:   if (mul_done) state_next = ST_GO_D;
            ST_GO_D:  state_next = ST_W_D;
            ST_W_D:   if (mul_done) state_next = ST_SUM;
            ST_SUM:   state_next = ST_GO_U;
            ST_GO_U:  state_next = ST_W_U;
            ST_W_U:   if (mul_done) state_next = ST_GO_V;
            ST_GO_V:  state_next = ST_W_V;
            ST_W_V:   if (mul_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_W_TS && mul_done)
            begin
                integ_reg <= integ_new;
                prev_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            err_reg <= err_in;
        end
        if (state_reg == ST_W_TS && mul_done)
        begin
            opnd_reg <= diff;
        end
        if (state_reg == ST_W_P && mul_done)
        begin
            term_reg <= 34'($signed(mul_sat));
        end
        if ((state_reg == ST_W_I || state_reg == ST_W_D) && mul_done)
        begin
            term_reg <= term_add;
        end
        if (state_reg == ST_SUM)
        begin
            opnd_reg <= pidc_pkg::sat32(term_reg);
        end
        if (state_reg == ST_W_U && mul_done)
        begin
            opnd_reg <= mul_sat;
        end
        if (state_reg == ST_W_V && mul_done)
        begin
            drive_reg   <= v2;
            clamped_reg <= cl;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign res.valid   = (state_reg == ST_OUT) && out_free;
    assign res.drive   = drive_reg;
    assign res.clamped = clamped_reg;

endmodule

// File: rtl/pid_controller_with_output_clamp_unit.sv
// Top level of the PID controller with clamped output: ports, result register, checks.
//
//  channel  dir  payload                                     handshake
//  s_*      in   tdata[31:0] measured, tdata[63:32] setpoint  tvalid/tready
//  m_*      out  tdata[31:0] drive, tuser clamped             tvalid/tready
//  apb      in   eight 32-bit registers at 4*index            psel/penable, pready=1
//
// Each item is worked out by six products run one after another on one bit-serial multiplier.
// Reset clears the integrator and previous error and loads the register defaults.
// A finished result waits in the output register while the next item is worked on;
// the sequencer stalls at its last step until that register is free.
module pid_controller_with_output_clamp_unit #(
    parameter int FRAC_BITS       = 16,
    parameter int INTEGRATOR_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // measured [31:0], setpoint [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive [31:0]
    output logic        m_tuser,   // clamped [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pidc_pkg::cfg_t           cfg;
    pidc_pkg::res_t           res;
    pidc_pkg::mul_ctl_t       mul_ctl;
    logic [31:0]              mul_a;
    logic [INTEGRATOR_BITS-1:0] mul_b;
    logic                     mul_done;
    logic [INTEGRATOR_BITS+32:0] mul_sh;
    logic [31:0]              mul_sat;

    logic                     m_valid_reg;
    logic [31:0]              drive_reg;
    logic                     clamped_reg;
    logic                     out_free;

    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pidc_mul #(
        .FB (FRAC_BITS),
        .IB (INTEGRATOR_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mul_ctl),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod_sh  (mul_sh),
        .prod_sat (mul_sat)
    );

    pidc_seq #(
        .FB (FRAC_BITS),
        .IB (INTEGRATOR_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .measured (s_tdata[31:0]),
        .setpoint (s_tdata[63:32]),
        .cfg      (cfg),
        .out_free (out_free),
        .res      (res),
        .mul_ctl  (mul_ctl),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_done (mul_done),
        .mul_sh   (mul_sh),
        .mul_sat  (mul_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            drive_reg   <= res.drive;
            clamped_reg <= res.clamped;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = clamped_reg;

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!m_valid_reg || m_tready))
        else $error("result written over an untaken item");

    a_clamped_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && clamped_reg |->
            (drive_reg == cfg.drive_max) || (drive_reg == cfg.drive_min))
        else $error("clamped drive not at a limit");

    a_free_within_limits: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !clamped_reg |->
            ($signed(drive_reg) <= $signed(cfg.drive_max)) &&
            ($signed(drive_reg) >= $signed(cfg.drive_min)))
        else $error("unclamped drive outside limits");
`endif

endmodule

// File: test/tb.sv
// Self-checking PID controller bench: paced stream traffic, register phases, drive/clamp check.
module tb;

    localparam int      FRAC        = 16;
    localparam int      INTEG_BITS  = 48;
    localparam longint  S32_HI      = 64'sd2147483647;
    localparam longint  S32_LO      = -64'sd2147483648;
    localparam longint  INTEG_HI    = (64'sd1 <<< (INTEG_BITS - 1)) - 1;
    localparam longint  INTEG_LO    = -INTEG_HI - 1;
    localparam longint  RUN_CYCLES  = 1_200_000;

    typedef struct packed {
        logic [31:0] setpoint;
        logic [31:0] measured;
    } sample_t;

    typedef struct {
        logic signed [31:0] drive;
        logic               clamped;
    } drive_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // measured [31:0], setpoint [63:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // drive [31:0]
    logic        m_tuser;          // clamped [0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sample_t     sample_q [$];
    drive_t      drive_q [$];
    int unsigned send_gap = 0;
    int unsigned take_gap = 0;
    int          mismatches = 0;
    logic        calm = 1'b0;
    logic [31:0] cfg_next [8];
    logic [31:0] phase_target = '0;

    logic signed [31:0] gain_total, gain_p, gain_i, gain_d, gain_out, lim_hi, lim_lo;
    logic [30:0]        step_dt;
    longint             integ;
    logic signed [31:0] prev_err;

    pid_controller_with_output_clamp_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
        if (v > S32_HI)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < S32_LO)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] qprod(input longint a, input longint b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return (wa * wb) >>> FRAC;
    endfunction

    function automatic logic signed [31:0] qmul(input longint a, input longint b);
        return clip32(qprod(a, b));
    endfunction

    function automatic drive_t pid_step(input sample_t s);
        drive_t              r;
        logic signed [127:0] pr;
        logic signed [31:0]  err, diff, total, scaled, v;
        longint              acc, p, i, d;
        err = clip32(longint'($signed(s.setpoint)) - longint'($signed(s.measured)));
        pr = qprod(longint'(err), longint'({33'd0, step_dt}));
        acc = integ + longint'(pr[63:0]);
        if (acc > INTEG_HI)
        begin
            acc = INTEG_HI;
        end
        if (acc < INTEG_LO)
        begin
            acc = INTEG_LO;
        end
        integ = acc;
        diff = clip32(longint'(err) - longint'(prev_err));
        p = qmul(longint'(gain_p), longint'(err));
        i = qmul(longint'(gain_i), integ);
        d = qmul(longint'(gain_d), longint'(diff));
        prev_err = err;
        total = clip32(p + i + d);
        scaled = qmul(longint'(gain_total), longint'(total));
        v = qmul(longint'(gain_out), longint'(scaled));
        r.clamped = 1'b0;
        if (v > lim_hi)
        begin
            v = lim_hi;
            r.clamped = 1'b1;
        end
        if (v < lim_lo)
        begin
            v = lim_lo;
            r.clamped = 1'b1;
        end
        r.drive = v;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
        begin
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'h0001_0000;
                endcase
            end
        endcase
    endfunction

    function automatic sample_t pick_sample();
        sample_t     s;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            s.measured = pick_edge();
            s.setpoint = pick_edge();
        end
        else if (r < 35)
        begin
            s.measured = $urandom;
            s.setpoint = $urandom;
        end
        else
        begin
            s.setpoint = phase_target + $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
            s.measured = phase_target + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end
        return s;
    endfunction

    // register shadow, updated on each completed write
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gain_total <= pidc_pkg::RST_TOTAL_GAIN;
            gain_p     <= '0;
            gain_i     <= '0;
            gain_d     <= '0;
            step_dt    <= pidc_pkg::RST_TIME_STEP;
            gain_out   <= pidc_pkg::RST_OUTPUT_GAIN;
            lim_hi     <= pidc_pkg::RST_DRIVE_MAX;
            lim_lo     <= pidc_pkg::RST_DRIVE_MIN;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                pidc_pkg::REG_TOTAL_GAIN:        gain_total <= pwdata;
                pidc_pkg::REG_PROPORTIONAL_GAIN: gain_p     <= pwdata;
                pidc_pkg::REG_INTEGRAL_GAIN:     gain_i     <= pwdata;
                pidc_pkg::REG_DERIVATIVE_GAIN:   gain_d     <= pwdata;
                pidc_pkg::REG_TIME_STEP:         step_dt    <= pwdata[30:0];
                pidc_pkg::REG_OUTPUT_GAIN:       gain_out   <= pwdata;
                pidc_pkg::REG_DRIVE_MAX:         lim_hi     <= pwdata;
                pidc_pkg::REG_DRIVE_MIN:         lim_lo     <= pwdata;
                default:                         ;
            endcase
        end
    end

    // sender: predict on acceptance, then present the next item or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
            integ    = 0;
            prev_err = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                drive_q = {drive_q, pid_step(sample_t'(s_tdata))};
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_tdata  <= sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each item against the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("drive: no item expected, got %0d", $signed(m_tdata));
                    mismatches++;
                end
                else
                begin
                    drive_t want;
                    want = drive_q.pop_front();
                    if (m_tdata !== want.drive)
                    begin
                        $error("drive: expected %0d, got %0d", want.drive, $signed(m_tdata));
                        mismatches++;
                    end
                    if (m_tuser !== want.clamped)
                    begin
                        $error("clamped: expected %0d, got %0d", want.clamped, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (take_gap != 0)
            begin
                take_gap <= take_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                begin
                    take_gap <= pick_gap();
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config();
        write_reg(pidc_pkg::REG_TOTAL_GAIN, cfg_next[pidc_pkg::REG_TOTAL_GAIN]);
        write_reg(pidc_pkg::REG_PROPORTIONAL_GAIN, cfg_next[pidc_pkg::REG_PROPORTIONAL_GAIN]);
        write_reg(pidc_pkg::REG_INTEGRAL_GAIN, cfg_next[pidc_pkg::REG_INTEGRAL_GAIN]);
        write_reg(pidc_pkg::REG_DERIVATIVE_GAIN, cfg_next[pidc_pkg::REG_DERIVATIVE_GAIN]);
        write_reg(pidc_pkg::REG_TIME_STEP, cfg_next[pidc_pkg::REG_TIME_STEP]);
        write_reg(pidc_pkg::REG_OUTPUT_GAIN, cfg_next[pidc_pkg::REG_OUTPUT_GAIN]);
        write_reg(pidc_pkg::REG_DRIVE_MAX, cfg_next[pidc_pkg::REG_DRIVE_MAX]);
        write_reg(pidc_pkg::REG_DRIVE_MIN, cfg_next[pidc_pkg::REG_DRIVE_MIN]);
    endtask

    task automatic push_pair(input logic [31:0] meas, input logic [31:0] setp);
        sample_t s;
        s.measured = meas;
        s.setpoint = setp;
        sample_q = {sample_q, s};
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            sample_q = {sample_q, pick_sample()};
        end
    endtask

    // hold until every prediction has been matched
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int unsigned lim;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_pair(32'h0000_0000, 32'h0001_0000);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h0000_0000, 32'h0000_0000);
        drain();

        cfg_next[pidc_pkg::REG_TOTAL_GAIN]        = 32'h0001_0000;
        cfg_next[pidc_pkg::REG_PROPORTIONAL_GAIN] = 32'h0001_0000;
        cfg_next[pidc_pkg::REG_INTEGRAL_GAIN]     = 32'h0000_4000;
        cfg_next[pidc_pkg::REG_DERIVATIVE_GAIN]   = 32'h0000_8000;
        cfg_next[pidc_pkg::REG_TIME_STEP]         = 32'h0001_0000;
        cfg_next[pidc_pkg::REG_OUTPUT_GAIN]       = 32'h0002_0000;
        cfg_next[pidc_pkg::REG_DRIVE_MAX]         = 32'h000A_0000;
        cfg_next[pidc_pkg::REG_DRIVE_MIN]         = 32'hFFF6_0000;
        load_config();
        push_pair(32'h0000_0000, 32'h0000_0000);
        push_pair(32'h0000_0000, 32'h0000_0001);
        push_pair(32'h0000_0001, 32'h0000_0000);
        push_pair(32'h0000_0000, 32'hFFFF_FFFF);
        push_pair(32'h0001_0000, 32'h0003_0000);
        push_pair(32'h0003_0000, 32'h0001_0000);
        push_pair(32'h0000_0000, 32'h0005_0000);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h7FFF_FFFF, 32'h8000_0000);
        push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pair(32'h8000_0000, 32'h8000_0000);
        push_pair(32'h0000_0000, 32'h7FFF_FFFF);
        push_pair(32'h0000_0000, 32'h8000_0000);
        push_pair(32'h7FFF_FFFF, 32'h0000_0000);
        push_pair(32'h8000_0000, 32'h0000_0000);
        push_pair(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        cfg_next[pidc_pkg::REG_TOTAL_GAIN]        = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_PROPORTIONAL_GAIN] = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_INTEGRAL_GAIN]     = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_DERIVATIVE_GAIN]   = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_TIME_STEP]         = 32'hFFFF_FFFF;
        cfg_next[pidc_pkg::REG_OUTPUT_GAIN]       = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_DRIVE_MAX]         = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_DRIVE_MIN]         = 32'h8000_0000;
        load_config();
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(32'h7FFF_FFFF, 32'h8000_0000);
        push_pair(32'h7FFF_FFFF, 32'h8000_0000);
        push_random(20);
        drain();

        cfg_next[pidc_pkg::REG_TOTAL_GAIN]        = 32'h8000_0000;
        cfg_next[pidc_pkg::REG_PROPORTIONAL_GAIN] = 32'h8000_0000;
        cfg_next[pidc_pkg::REG_INTEGRAL_GAIN]     = 32'h8000_0000;
        cfg_next[pidc_pkg::REG_DERIVATIVE_GAIN]   = 32'h8000_0000;
        cfg_next[pidc_pkg::REG_TIME_STEP]         = 32'h0000_0000;
        cfg_next[pidc_pkg::REG_OUTPUT_GAIN]       = 32'h8000_0000;
        cfg_next[pidc_pkg::REG_DRIVE_MAX]         = 32'h7FFF_FFFF;
        cfg_next[pidc_pkg::REG_DRIVE_MIN]         = 32'h8000_0000;
        load_config();
        push_random(20);
        drain();

        cfg_next[pidc_pkg::REG_TOTAL_GAIN]        = 32'h0001_0000;
        cfg_next[pidc_pkg::REG_PROPORTIONAL_GAIN] = 32'h0000_C000;
        cfg_next[pidc_pkg::REG_INTEGRAL_GAIN]     = 32'h0000_2000;
        cfg_next[pidc_pkg::REG_DERIVATIVE_GAIN]   = 32'hFFFF_8000;
        cfg_next[pidc_pkg::REG_TIME_STEP]         = 32'h8000_4000;
        cfg_next[pidc_pkg::REG_OUTPUT_GAIN]       = 32'h0001_0000;
        cfg_next[pidc_pkg::REG_DRIVE_MAX]         = 32'hFFFF_0000;
        cfg_next[pidc_pkg::REG_DRIVE_MIN]         = 32'h0001_0000;
        load_config();
        push_random(20);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            phase_target = ($urandom_range(0, 3) == 0) ? $urandom : pick_coef(1);
            for (int r = 0; r < 8; r++)
            begin
                cfg_next[r] = pick_coef(($urandom_range(0, 4) == 0) ? 0 :
                                        ($urandom_range(0, 5) == 0) ? 2 : 1);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                lim = $urandom_range(32'h0001_0000, 32'h0020_0000);
                cfg_next[pidc_pkg::REG_DRIVE_MAX] = lim;
                cfg_next[pidc_pkg::REG_DRIVE_MIN] = -lim;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                cfg_next[pidc_pkg::REG_TIME_STEP] = $urandom_range(0, 32'h0002_0000) |
                                                    ($urandom_range(0, 1) << 31);
            end
            load_config();
            push_random(55);
            drain();
        end

        calm = 1'b0;
        repeat (260) @(negedge clk);
        if (mismatches == 0 && drive_q.size() == 0)
        begin
            $display("[pid_controller_with_output_clamp_unit] OK");
        end
        else
        begin
            $display("[pid_controller_with_output_clamp_unit] ERROR");
        end
        $finish;
    end

    initial
    begin
        #(RUN_CYCLES * 12);
        $display("[pid_controller_with_output_clamp_unit] ERROR");
        $finish;
    end

endmodule
